// ===== rtl/core/cdq_pkg.sv =====
// Shared types, constants and helpers for the codebook dequant dot-product unit.
// No dependencies.
package cdq_pkg;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // Control tag that travels with a step item down the lanes.
    typedef struct packed {
        logic v;       // stage holds a step item
        logic single;  // only the low index contributes
        logic emit;    // this item closes the dot product
    } t_ctl;

    // Leading zeros of a nonzero 48-bit word.
    function automatic logic [5:0] lead_zeros48(input logic [47:0] v);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) cnt = 6'(47 - i);
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/codebook_dequant_dot_product_unit.sv =====
// Top level of the codebook dequant dot-product unit: codebook RAM, two multiply
// lanes and the ordered accumulator. Depends on cdq_pkg, cdq_ram, cdq_fp_mul, cdq_accum.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall       | cmd, entry_index, centroid_half,
//          |           |                               | packed_pair, activations
//  out     | output    | o_out_valid / i_out_stall     | o_dot_result
//  cfg     | input     | i_cfg_valid / o_cfg_ready     | i_cfg_data (reduction_length)
//
// Accumulator: a step item passes through two serial FP adds, one on the odd tail;
// that loop-carried sum sets the rate: a new step item is taken only once the adds of the last one are done.
// Path from accept to result: registered RAM read + 3 multiply stages + the adds + output reg.
// Reset: synchronous active low; clears sum, count, length (to 1) and valids. The
// codebook is not cleared.
// Stalls: the lane pipeline holds as a whole while the accumulator cannot take its item.
module codebook_dequant_dot_product_unit #(
    parameter int CODEBOOK_ENTRIES = 4096,
    parameter int INDEX_BITS       = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [11:0] i_entry_index,
    input  logic [15:0] i_centroid_half,
    input  logic [23:0] i_packed_pair,
    input  logic [31:0] i_activation_first,
    input  logic [31:0] i_activation_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_dot_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(CODEBOOK_ENTRIES);

    // FP16 -> FP32, exact; subnormal halves become normal singles
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  p;
        logic [23:0] t;
        p = 5'd0;
        t = 24'd0;
        for (int i = 0; i < 10; i++) begin
            if (h[i]) p = 5'(i);
        end
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) return {h[15], 31'd0};
            t = {14'd0, h[9:0]} << (5'd23 - p);
            return {h[15], 8'(p) + 8'd103, t[22:0]};
        end
        if (h[14:10] == 5'h1F) begin
            if (h[9:0] != 10'd0) return cdq_pkg::QNAN;
            return {h[15], 8'hFF, 23'd0};
        end
        return {h[15], {3'b000, h[14:10]} + 8'd112, h[9:0], 13'd0};
    endfunction

    // config register
    logic [15:0] r_len;
    assign o_cfg_ready = 1'b1;

    // accept and count
    logic          en, take, accept, step_acc, load_we;
    logic [31:0]   pk32, idx0_32, idx1_32, slot32;
    logic          oob0, oob1;
    logic [15:0]   len;
    logic [15:0]   r_cnt;
    logic [16:0]   newc;
    logic          single, emit;

    assign accept   = i_in_valid & en;
    assign step_acc = accept & i_cmd;
    assign o_in_stall = ~en;

    always_comb begin
        pk32    = {8'd0, i_packed_pair};
        idx0_32 = {{(32 - INDEX_BITS){1'b0}}, pk32[INDEX_BITS-1:0]};
        idx1_32 = {{(32 - INDEX_BITS){1'b0}}, pk32[2*INDEX_BITS-1:INDEX_BITS]};
        oob0    = idx0_32 >= 32'(CODEBOOK_ENTRIES);
        oob1    = idx1_32 >= 32'(CODEBOOK_ENTRIES);
        slot32  = {20'd0, i_entry_index};
        load_we = accept & ~i_cmd & (slot32 < 32'(CODEBOOK_ENTRIES));
        len     = (r_len == 16'd0) ? 16'd1 : r_len;
        single  = ({1'b0, r_cnt} + 17'd1) >= {1'b0, len};
        newc    = {1'b0, r_cnt} + (single ? 17'd1 : 17'd2);
        emit    = newc >= {1'b0, len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 16'd1;
            r_cnt <= 16'd0;
        end else begin
            if (i_cfg_valid) r_len <= i_cfg_data;
            if (step_acc)    r_cnt <= emit ? 16'd0 : newc[15:0];
        end
    end

    // codebook
    logic [31:0] rd0, rd1;

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (CODEBOOK_ENTRIES)
    ) u_codebook (
        .i_clk     (i_clk),
        .i_we      (load_we),
        .i_waddr   (slot32[AW-1:0]),
        .i_wdata   (widen_half(i_centroid_half)),
        .i_re      (step_acc),
        .i_raddr_a (idx0_32[AW-1:0]),
        .i_raddr_b (idx1_32[AW-1:0]),
        .o_rdata_a (rd0),
        .o_rdata_b (rd1)
    );

    // read stage
    cdq_pkg::t_ctl r_ctl_r, r_ctl_1, r_ctl_2, r_ctl_3;
    logic [31:0]   r_act0, r_act1;
    logic          r_oob0, r_oob1;
    logic [31:0]   cent0, cent1, prod0, prod1;

    assign en = ~r_ctl_3.v | take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_r <= '0;
            r_ctl_1 <= '0;
            r_ctl_2 <= '0;
            r_ctl_3 <= '0;
        end else if (en) begin
            r_ctl_r <= '{v: step_acc, single: single, emit: emit};
            r_ctl_1 <= r_ctl_r;
            r_ctl_2 <= r_ctl_1;
            r_ctl_3 <= r_ctl_2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_act0 <= i_activation_first;
            r_act1 <= i_activation_second;
            r_oob0 <= oob0;
            r_oob1 <= oob1;
        end
    end

    assign cent0 = r_oob0 ? 32'd0 : rd0;
    assign cent1 = r_oob1 ? 32'd0 : rd1;

    // two multiply lanes
    cdq_fp_mul u_lane0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (cent0),
        .i_b   (r_act0),
        .o_p   (prod0)
    );

    cdq_fp_mul u_lane1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (cent1),
        .i_b   (r_act1),
        .o_p   (prod1)
    );

    // ordered merge into the running sum
    cdq_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_ctl_3),
        .i_prod0      (prod0),
        .i_prod1      (prod1),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_dot_result (o_dot_result)
    );

endmodule

// ===== rtl/core/cdq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== rtl/core/cdq_fp_mul.sv =====
// One multiply lane: FP32 x FP32, round to nearest even, three stages.
// Depends on cdq_pkg.
module cdq_fp_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    // stage 1: unpack, 24x24 product
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         eea, eeb;
    logic [23:0]        ma, mb;
    logic [47:0]        r1_prod;
    logic signed [10:0] r1_exp;
    logic               r1_sign, r1_nan, r1_inf, r1_zero;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        eea    = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eeb    = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma     = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb     = {(i_b[30:23] != 8'd0), i_b[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= ma * mb;
            r1_exp  <= $signed({3'b000, eea} + {3'b000, eeb}) - 11'sd126;
            r1_sign <= i_a[31] ^ i_b[31];
            r1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            r1_inf  <= a_inf | b_inf;
            r1_zero <= a_zero | b_zero;
        end
    end

    // stage 2: normalize leading one to bit 47
    logic [5:0]         lz;
    logic [47:0]        r2_n;
    logic signed [10:0] r2_exp;
    logic               r2_sign, r2_nan, r2_inf, r2_zero;

    assign lz = cdq_pkg::lead_zeros48(r1_prod);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n    <= r1_prod << lz;
            r2_exp  <= r1_exp - $signed({5'b00000, lz});
            r2_sign <= r1_sign;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
            r2_zero <= r1_zero | (r1_prod == 48'd0);
        end
    end

    // stage 3: subnormal shift and rounding
    logic signed [10:0] one_minus;
    logic [5:0]         sh;
    logic [47:0]        shifted;
    logic               lost, g, st, inc;
    logic [7:0]         efield;
    logic [30:0]        rounded;
    logic [31:0]        res;
    logic [31:0]        r_p;

    always_comb begin
        one_minus = 11'sd1 - r2_exp;
        if (r2_exp > 11'sd0)          sh = 6'd0;
        else if (one_minus > 11'sd63) sh = 6'd63;
        else                          sh = one_minus[5:0];
        shifted = r2_n >> sh;
        lost    = |(r2_n & ~({48{1'b1}} << sh));
        g       = shifted[23];
        st      = (|shifted[22:0]) | lost;
        inc     = g & (st | shifted[24]);
        efield  = (r2_exp > 11'sd0) ? r2_exp[7:0] : 8'd0;
        rounded = {efield, shifted[46:24]} + {30'd0, inc};
        if (r2_nan)                    res = cdq_pkg::QNAN;
        else if (r2_inf)               res = {r2_sign, 8'hFF, 23'd0};
        else if (r2_zero)              res = {r2_sign, 31'd0};
        else if (r2_exp > 11'sd254)    res = {r2_sign, 8'hFF, 23'd0};
        else                           res = {r2_sign, rounded};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= res;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/cdq_fp_add.sv =====
// FP32 adder, round to nearest even, two stages, free running.
// Depends on cdq_pkg.
module cdq_fp_add (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    // stage 1: order by magnitude, align, add
    logic        a_nan, b_nan, a_inf, b_inf, swap, sub;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my, shr, al;
    logic        lost;
    logic [27:0] r_s;
    logic [7:0]  r_e;
    logic        r_sign, r_zsign, r_nan, r_inf, r_isign;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        swap  = i_b[30:0] > i_a[30:0];
        x     = swap ? i_b : i_a;
        y     = swap ? i_a : i_b;
        sub   = x[31] ^ y[31];
        ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d     = ex - ey;
        mx    = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        my    = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        shr   = my >> d;
        lost  = |(my & ~({27{1'b1}} << d));
        al    = {shr[26:1], shr[0] | lost};
    end

    always_ff @(posedge i_clk) begin
        r_s     <= sub ? ({1'b0, mx} - {1'b0, al}) : ({1'b0, mx} + {1'b0, al});
        r_e     <= ex;
        r_sign  <= x[31];
        r_zsign <= sub ? 1'b0 : x[31];
        r_nan   <= a_nan | b_nan | (a_inf & b_inf & (i_a[31] != i_b[31]));
        r_inf   <= a_inf | b_inf;
        r_isign <= a_inf ? i_a[31] : i_b[31];
    end

    // stage 2: normalize and round
    logic [5:0]  lz;
    logic [7:0]  maxsh, sh;
    logic [26:0] n;
    logic [8:0]  e9;
    logic [7:0]  efield;
    logic        g, st, inc;
    logic [30:0] rounded;
    logic [31:0] res;
    logic [31:0] r_out;

    always_comb begin
        lz    = cdq_pkg::lead_zeros48({r_s[26:0], 21'd0});
        maxsh = r_e - 8'd1;
        sh    = ({2'b00, lz} <= maxsh) ? {2'b00, lz} : maxsh;
        if (r_s[27]) begin
            n  = {r_s[27:2], r_s[1] | r_s[0]};
            e9 = {1'b0, r_e} + 9'd1;
        end else begin
            n  = r_s[26:0] << sh;
            e9 = {1'b0, r_e} - {1'b0, sh};
        end
        efield  = n[26] ? e9[7:0] : 8'd0;
        g       = n[2];
        st      = n[1] | n[0];
        inc     = g & (st | n[3]);
        rounded = {efield, n[25:3]} + {30'd0, inc};
        if (r_nan)                 res = cdq_pkg::QNAN;
        else if (r_inf)            res = {r_isign, 8'hFF, 23'd0};
        else if (r_s == 28'd0)     res = {r_zsign, 31'd0};
        else if (e9 >= 9'd255)     res = {r_sign, 8'hFF, 23'd0};
        else                       res = {r_sign, rounded};
    end

    always_ff @(posedge i_clk) begin
        r_out <= res;
    end

    assign o_s = r_out;

endmodule

// ===== rtl/core/cdq_accum.sv =====
// Merge stage: adds lane products into the running sum in order, emits results.
// Depends on cdq_pkg and cdq_fp_add.
module cdq_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdq_pkg::t_ctl   i_ctl,
    input  logic [31:0]     i_prod0,
    input  logic [31:0]     i_prod1,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_dot_result
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAIT1 = 6'b000010,
        S_DONE1 = 6'b000100,
        S_WAIT2 = 6'b001000,
        S_DONE2 = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    function automatic logic [31:0] canon(input logic [31:0] v);
        if ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) return cdq_pkg::QNAN;
        return v;
    endfunction

    t_state        r_state, n_state;
    logic [31:0]   r_sum, n_sum;
    cdq_pkg::t_ctl r_cur, n_cur;
    logic [31:0]   r_p1, n_p1;
    logic          r_o_v, n_o_v;
    logic [31:0]   r_o_data, n_o_data;
    logic [31:0]   op_a, op_b, add_out, base;
    logic          out_free, finish;

    cdq_fp_add u_add (
        .i_clk (i_clk),
        .i_a   (op_a),
        .i_b   (op_b),
        .o_s   (add_out)
    );

    always_comb begin
        o_take   = 1'b0;
        op_a     = r_sum;
        op_b     = i_prod0;
        n_state  = r_state;
        n_sum    = r_sum;
        n_cur    = r_cur;
        n_p1     = r_p1;
        n_o_v    = r_o_v & i_out_stall;
        n_o_data = r_o_data;
        out_free = ~r_o_v | ~i_out_stall;
        finish   = 1'b0;
        base     = 32'd0;
        case (r_state)
            S_IDLE: begin
                if (i_ctl.v) begin
                    o_take  = 1'b1;
                    n_cur   = i_ctl;
                    n_p1    = i_prod1;
                    n_state = S_WAIT1;
                end
            end
            S_WAIT1: n_state = S_DONE1;
            S_DONE1: begin
                if (r_cur.single) begin
                    finish = 1'b1;
                end else begin
                    op_a    = add_out;
                    op_b    = r_p1;
                    n_state = S_WAIT2;
                end
            end
            S_WAIT2: n_state = S_DONE2;
            S_DONE2: finish = 1'b1;
            S_HOLD: begin
                if (out_free) begin
                    n_o_v    = 1'b1;
                    n_o_data = canon(r_sum);
                    n_sum    = 32'd0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (finish) begin
            if (r_cur.emit && !out_free) begin
                // result slot busy: park the total in the sum register
                n_sum   = add_out;
                n_state = S_HOLD;
            end else begin
                base = r_cur.emit ? 32'd0 : add_out;
                if (r_cur.emit) begin
                    n_o_v    = 1'b1;
                    n_o_data = canon(add_out);
                end
                n_sum = base;
                if (i_ctl.v) begin
                    o_take  = 1'b1;
                    op_a    = base;
                    op_b    = i_prod0;
                    n_cur   = i_ctl;
                    n_p1    = i_prod1;
                    n_state = S_WAIT1;
                end else begin
                    n_state = S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= 32'd0;
            r_o_v   <= 1'b0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_o_v   <= n_o_v;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= n_p1;
        r_o_data <= n_o_data;
    end

    assign o_out_valid  = r_o_v;
    assign o_dot_result = r_o_data;

endmodule

// ===== tb/dot_sum_monitor.sv =====
`timescale 1ns / 1ps
// Watches the in, out and cfg channels of the codebook dequant dot-product unit,
// predicts each dot product in FP32 and compares it. Depends on cdq_pkg.
module dot_sum_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [11:0] i_entry_index,
    input  logic [15:0] i_centroid_half,
    input  logic [23:0] i_packed_pair,
    input  logic [31:0] i_activation_first,
    input  logic [31:0] i_activation_second,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_dot_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [31:0] centroids [4096];
    logic [31:0] sum_bits;
    logic [16:0] done_cnt;
    logic [15:0] red_len;
    logic [31:0] dot_q[$];

    // FP32 bits -> double, exact
    function automatic real f32_to_real(input logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF) begin
            return $bitstoreal(f[22:0] != 0 ? 64'h7FF8_0000_0000_0000
                                            : {f[31], 11'h7FF, 52'd0});
        end
        if (f[30:23] == 8'd0) begin
            if (f[22:0] == 0) return $bitstoreal({f[31], 63'd0});
            r = f[22:0] * $bitstoreal(64'h36A0_0000_0000_0000);  // 2^-149
            return f[31] ? -r : r;
        end
        return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0});
    endfunction

    // double -> FP32 bits, round to nearest even, subnormals kept
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] d, sig, kept, res, base;
        int ex, sh;
        logic half, sticky;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF) return d[51:0] != 0 ? cdq_pkg::QNAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0) return {d[63], 31'd0};
        sig = {11'd0, 1'b1, d[51:0]};
        ex = int'(d[62:52]) - 1023;
        if (ex > 127) return {d[63], 8'hFF, 23'd0};
        if (ex >= -126) begin
            sh = 29;
            base = 64'(ex + 126) << 23;
        end else begin
            sh = 29 + (-126 - ex);
            base = 0;
        end
        if (sh > 54) sh = 54;
        kept = sig >> sh;
        half = sig[sh-1];
        sticky = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
        if (half && (sticky || kept[0])) kept++;
        res = base + kept;
        if (res >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
        return {d[63], res[30:0]};
    endfunction

    function automatic logic [31:0] widen_fp16(input logic [15:0] h);
        logic [31:0] b;
        if (h[14:10] == 5'd0) begin
            b = real_to_f32(h[9:0] * $bitstoreal(64'h3E70_0000_0000_0000));  // 2^-24
            b[31] = h[15];
            return b;
        end
        if (h[14:10] == 5'h1F) return h[9:0] != 0 ? cdq_pkg::QNAN : {h[15], 8'hFF, 23'd0};
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] mac_f32(input logic [31:0] acc, input logic [31:0] w,
                                            input logic [31:0] a);
        logic [31:0] prod;
        prod = real_to_f32(f32_to_real(w) * f32_to_real(a));
        return real_to_f32(f32_to_real(acc) + f32_to_real(prod));
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        o_errors++;
        $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [16:0] len;
        logic [31:0] got;
        if (!i_rst_n) begin
            sum_bits <= 32'd0;
            done_cnt <= '0;
            red_len  <= 16'd1;
            dot_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) red_len <= i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (!i_cmd) begin
                    centroids[i_entry_index] = widen_fp16(i_centroid_half);
                end else begin
                    logic [31:0] s;
                    logic [16:0] n;
                    len = red_len == 16'd0 ? 17'd1 : 17'(red_len);
                    s = mac_f32(sum_bits, centroids[i_packed_pair[11:0]],
                                i_activation_first);
                    if (done_cnt + 17'd1 >= len) begin
                        n = done_cnt + 17'd1;
                    end else begin
                        s = mac_f32(s, centroids[i_packed_pair[23:12]], i_activation_second);
                        n = done_cnt + 17'd2;
                    end
                    if (n >= len) begin
                        dot_q.push_back(s);
                        s = 32'd0;
                        n = '0;
                    end
                    sum_bits <= s;
                    done_cnt <= n;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_dot_result;
                if (dot_q.size() == 0) report("unexpected dot result", got, 32'd0);
                else begin
                    logic [31:0] want;
                    want = dot_q.pop_front();
                    if (got !== want) report("dot_result", got, want);
                end
            end
        end
        o_pending = dot_q.size();
    end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for codebook_dequant_dot_product_unit. The dot_sum_monitor
// beside the block predicts and checks. Depends on cdq_pkg and the RTL.
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic [11:0] i_entry_index;
    logic [15:0] i_centroid_half;
    logic [23:0] i_packed_pair;
    logic [31:0] i_activation_first;
    logic [31:0] i_activation_second;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_dot_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;

    // codebook slots written so far; steps only index these
    logic        loaded [4096];
    logic [11:0] loaded_list[$];
    int          burst_left;
    int          stall_mode;

    codebook_dequant_dot_product_unit uut (.*);

    dot_sum_monitor mon (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall),
        .i_cmd, .i_entry_index, .i_centroid_half, .i_packed_pair,
        .i_activation_first, .i_activation_second,
        .i_out_valid(o_out_valid),
        .i_out_stall,
        .i_dot_result(o_dot_result),
        .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data,
        .o_errors(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver stall: switches among no stall, light and heavy random stall
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= $urandom_range(0, 99) < 30;
            end
            default: begin
                i_out_stall <= $urandom_range(0, 99) < 75;
            end
        endcase
    end

    // One item on the in channel. Sender runs in bursts; a gap of zero keeps valid
    // high so it is never lowered and raised in the same step.
    task automatic push_item(input logic cmd, input logic [11:0] slot,
                             input logic [15:0] half, input logic [23:0] pair,
                             input logic [31:0] act_a, input logic [31:0] act_b);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid          <= 1'b1;
        i_cmd               <= cmd;
        i_entry_index       <= slot;
        i_centroid_half     <= half;
        i_packed_pair       <= pair;
        i_activation_first  <= act_a;
        i_activation_second <= act_b;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic load_entry(input logic [11:0] slot, input logic [15:0] half);
        push_item(1'b0, slot, half, 24'($urandom), $urandom, $urandom);
        if (!loaded[slot]) begin
            loaded[slot] = 1'b1;
            loaded_list.push_back(slot);
        end
    endtask

    task automatic step_pair(input logic [11:0] lo, input logic [11:0] hi,
                             input logic [31:0] act_a, input logic [31:0] act_b);
        push_item(1'b1, 12'($urandom), 16'($urandom), {hi, lo}, act_a, act_b);
    endtask

    // Stop sending and let every expected dot product come out, plus the pipe depth
    // so a step that closes nothing has left the lanes too.
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [15:0] len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_half();
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] rand_act();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
    endfunction

    function automatic logic [11:0] pick_slot();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    task automatic random_items(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 15) load_entry(12'($urandom), rand_half());
            else step_pair(pick_slot(), pick_slot(), rand_act(), rand_act());
        end
    endtask

    initial begin
        logic [15:0] special_half [12];
        logic [31:0] special_act [8];
        int lengths [7];
        special_half = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h8001, 16'h7BFF,
                         16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'h3C00, 16'hC000};
        special_act = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001,
                        32'h7F7F_FFFF, 32'h3F80_0000, 32'h8000_0000, 32'h0080_0000};
        lengths = '{2, 3, 0, 7, 16, 5, 1};
        stall_mode = 0;
        burst_left = 0;
        foreach (loaded[k]) loaded[k] = 1'b0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_cmd = 0;
        i_entry_index = 0;
        i_centroid_half = 0;
        i_packed_pair = 0;
        i_activation_first = 0;
        i_activation_second = 0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: special FP16 centroids at both index extremes and in between
        load_entry(12'd0, special_half[10]);
        load_entry(12'd4095, special_half[11]);
        for (int k = 0; k < 12; k++) load_entry(12'(k + 1), special_half[k]);
        // length 1 after reset: every step is a single-product odd tail
        for (int k = 0; k < 8; k++) step_pair(12'(k + 1), 12'd4095, special_act[k], 32'd0);
        set_length(16'd2);
        step_pair(12'd0, 12'd4095, 32'hFFFF_FFFF, 32'h0000_0000);
        step_pair(12'd4095, 12'd0, 32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow to inf
        step_pair(12'd7, 12'd8, 32'h3F80_0000, 32'h3F80_0000);      // inf + -inf
        step_pair(12'd3, 12'd5, 32'h0000_0001, 32'h8000_0001);      // subnormal operands, products underflow to zero

        // Random phases over several lengths, mid-sum length changes included
        for (int p = 0; p < 7; p++) begin
            set_length(16'(lengths[p]));
            random_items($urandom_range(140, 200));
            if (p == 3) begin
                drain();           // sender waits for every dot product
                random_items(40);
            end
        end

        // Longest length: a partial sum, then the length drops below the count
        // so the next step closes the sum as an odd tail
        set_length(16'hFFFF);
        random_items(60);
        set_length(16'd1);
        random_items(20);

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
